/* hdl/pg_pkg.sv */
// Shared types and constants of the polar-to-grid max-hold block.
`timescale 1ns / 1ps

package pg_pkg;

	// Item kinds carried in the input tuser.
	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_START = 2'd1,
		MODE_GROUP = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	// Configuration register indexes.
	localparam logic [7:0] CFG_INVALID_LIMIT = 8'd0;
	localparam logic [7:0] CFG_RANGE_GROUPS  = 8'd1;

	// Configuration reset values.
	localparam logic [7:0] LIMIT_RESET  = 8'd1;
	localparam logic [7:0] GROUPS_RESET = 8'd115;

	// Gate group shape and code folding.
	localparam int GATES_PER_GROUP = 4;
	localparam int CODE_W          = 8;
	localparam int MAG_W           = 9;
	localparam logic [MAG_W-1:0] FOLD_BELOW = 9'd129;
	localparam logic [MAG_W-1:0] FOLD_BASE  = 9'd258;

	// Field widths of the streams.
	localparam int POS_W      = 32;
	localparam int IDX_IN_W   = 6;
	localparam int PEAK_POS_W = 7;
	localparam int IN_DATA_W  = 176;
	localparam int OUT_DATA_W = 32;

	typedef logic [CODE_W-1:0] code_t;
	typedef code_t [GATES_PER_GROUP-1:0] codes_t;

endpackage

/* hdl/polar_to_grid_max_velocity.sv */
// Top level of the polar-to-grid max-hold block for radar velocity codes.
// Usage:
//   Input words arrive on in_tvalid/in_tready; in_tuser selects the kind of word
//   (clear grid, start radial, gate group, read box) and in_tdata carries the
//   start positions, steps, four gate codes and read coordinates.
//   Every accepted word gives exactly one result word on out_tvalid/out_tready,
//   carrying the box value, the peak and its position, and the off-grid flag.
//   Start, gate group and read words issue the grid memory read in the accept
//   cycle; the update state then folds the gates, updates the box and loads the
//   output register. A new word is taken only once that read-modify-write is done.
//   A clear word walks the grid memory one box per cycle, zeroing every box, before
//   the update state gives its result. After reset the same sweep zeroes the grid;
//   in_tready stays low meanwhile, while configuration writes are taken.
//   The output register lets the next word be accepted while a result waits;
//   if the receiver stalls, that next word holds in the update cycle until the
//   output register frees up, and in_tready stays low until then.
//   Configuration writes on cfg_valid/cfg_ready are always taken; the user is to
//   issue them in idle periods only, as the block does not enforce this.
`timescale 1ns / 1ps

module polar_to_grid_max_velocity
	import pg_pkg::*;
#(
	parameter int GRID_COLS = 64,
	parameter int GRID_ROWS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream.
	input  logic                  in_tvalid,
	output logic                  in_tready,
	// Fields from bit 0: col_start[31:0], row_start[63:32], col_step[95:64],
	// row_step[127:96], vel_gate_0..3[159:128], read_col[165:160],
	// read_row[171:166], zero fill to 176.
	input  logic [IN_DATA_W-1:0]  in_tdata,
	// Fields from bit 0: mode[1:0].
	input  logic [1:0]            in_tuser,
	// Result stream.
	output logic                  out_tvalid,
	input  logic                  out_tready,
	// Fields from bit 0: box_value[8:0], peak_value[17:9], peak_col[24:18],
	// peak_row[31:25].
	output logic [OUT_DATA_W-1:0] out_tdata,
	// Fields from bit 0: off_grid[0].
	output logic                  out_tuser,
	// Configuration write channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_index,
	input  logic [7:0]            cfg_data
);

	localparam int DEPTH = GRID_COLS * GRID_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(GRID_COLS);
	localparam int RW    = $clog2(GRID_ROWS);
	localparam int PCW   = $clog2(GRID_COLS + 1);
	localparam int PRW   = $clog2(GRID_ROWS + 1);
	localparam logic [AW-1:0] COLS_A    = AW'(GRID_COLS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [15:0]   COLS_16   = 16'(GRID_COLS);
	localparam logic [15:0]   ROWS_16   = 16'(GRID_ROWS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_UPD  = 3'b010,
		ST_CLR  = 3'b100
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [CODE_W-1:0] limit_q;
	logic [7:0]        range_groups_q;

	// Radial state.
	logic [POS_W-1:0] col_pos_q, row_pos_q, col_inc_q, row_dec_q;
	logic [7:0]       group_count_q;
	logic [MAG_W-1:0] best_value_q;
	logic [PCW-1:0]   best_col_q;
	logic [PRW-1:0]   best_row_q;

	// Word held for the update cycle.
	mode_t          mode_q;
	codes_t         codes_q;
	logic           on_grid_q;
	logic           in_range_q;
	logic [AW-1:0]  addr_q;
	logic [PCW-1:0] ci_q;
	logic [PRW-1:0] ri_q;

	// Clear sweep.
	logic [AW-1:0] clr_q;
	logic          clr_emit_q;

	// Output register.
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_user_q;

	// Input field views.
	mode_t                in_mode;
	logic [POS_W-1:0]     in_col_start, in_row_start, in_col_step, in_row_step;
	codes_t               in_codes;
	logic [IDX_IN_W-1:0]  in_read_col, in_read_row;

	assign in_mode      = mode_t'(in_tuser);
	assign in_col_start = in_tdata[31:0];
	assign in_row_start = in_tdata[63:32];
	assign in_col_step  = in_tdata[95:64];
	assign in_row_step  = in_tdata[127:96];
	assign in_codes     = in_tdata[159:128];
	assign in_read_col  = in_tdata[165:160];
	assign in_read_row  = in_tdata[171:166];

	logic accept;
	logic upd_fire;
	assign in_tready = (state_q == ST_IDLE);
	assign accept    = in_tvalid && in_tready;
	assign upd_fire  = (state_q == ST_UPD) && (!out_valid_q || out_tready);
	assign cfg_ready = 1'b1;

	// Box address of the current radial position or of the read coordinates.
	logic [15:0]    ci16, ri16, ci_m1, ri_m1;
	logic           pos_on_grid;
	logic [AW-1:0]  pos_addr;
	logic [15:0]    rc16, rr16;
	logic           rd_on_grid;
	logic [AW-1:0]  rd_addr;
	logic [AW-1:0]  acc_addr;
	logic           acc_on_grid;

	always_comb begin
		ci16        = col_pos_q[31:16];
		ri16        = row_pos_q[31:16];
		ci_m1       = ci16 - 16'd1;
		ri_m1       = ri16 - 16'd1;
		pos_on_grid = (ci16 != 16'd0) && (ci16 <= COLS_16) &&
		              (ri16 != 16'd0) && (ri16 <= ROWS_16);
		pos_addr    = AW'(ri_m1[RW-1:0]) * COLS_A + AW'(ci_m1[CW-1:0]);
		rc16        = 16'(in_read_col);
		rr16        = 16'(in_read_row);
		rd_on_grid  = (rc16 < COLS_16) && (rr16 < ROWS_16);
		rd_addr     = AW'(rr16[RW-1:0]) * COLS_A + AW'(rc16[CW-1:0]);
		if (in_mode == MODE_READ) begin
			acc_addr    = rd_addr;
			acc_on_grid = rd_on_grid;
		end else begin
			acc_addr    = pos_addr;
			acc_on_grid = pos_on_grid;
		end
	end

	// Gate group magnitude.
	logic [MAG_W-1:0] group_max;

	pg_gate_max u_gate_max (
		.codes     (codes_q),
		.limit     (limit_q),
		.group_max (group_max)
	);

	// Grid memory.
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [MAG_W-1:0] ram_wdata;
	logic [MAG_W-1:0] ram_rdata;

	pg_grid_ram #(
		.AW (AW),
		.DW (MAG_W)
	) u_grid_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (acc_addr),
		.rdata (ram_rdata)
	);

	// Update decision for the held word.
	logic             do_write;
	logic             new_peak;
	logic [MAG_W-1:0] box_val;
	logic             off_val;

	always_comb begin
		do_write = (mode_q == MODE_GROUP) && in_range_q && on_grid_q &&
		           (group_max != '0) && (group_max > ram_rdata);
		new_peak = do_write && (group_max > best_value_q);
		box_val  = '0;
		off_val  = 1'b0;
		unique case (mode_q)
			MODE_GROUP: begin
				if (in_range_q) begin
					if (on_grid_q) begin
						box_val = do_write ? group_max : ram_rdata;
					end else begin
						off_val = 1'b1;
					end
				end
			end
			MODE_READ: begin
				if (on_grid_q) begin
					box_val = ram_rdata;
				end else begin
					off_val = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Memory write source: clear sweep or box update.
	always_comb begin
		if (state_q == ST_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = upd_fire && do_write;
			ram_waddr = addr_q;
			ram_wdata = group_max;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_q      <= '0;
			clr_emit_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_mode == MODE_CLEAR) begin
							state_q    <= ST_CLR;
							clr_q      <= '0;
							clr_emit_q <= 1'b1;
						end else begin
							state_q <= ST_UPD;
						end
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_ADDR) begin
						state_q <= clr_emit_q ? ST_UPD : ST_IDLE;
					end
				end
				ST_UPD: begin
					if (upd_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q        <= LIMIT_RESET;
			range_groups_q <= GROUPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_INVALID_LIMIT) begin
				limit_q <= cfg_data;
			end else if (cfg_index == CFG_RANGE_GROUPS) begin
				range_groups_q <= cfg_data;
			end
		end
	end

	// Radial position, group count and peak.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q     <= '0;
			row_pos_q     <= '0;
			col_inc_q     <= '0;
			row_dec_q     <= '0;
			group_count_q <= '0;
			best_value_q  <= '0;
			best_col_q    <= '0;
			best_row_q    <= '0;
		end else begin
			if (accept) begin
				priority if (in_mode == MODE_CLEAR) begin
					best_value_q <= '0;
					best_col_q   <= '0;
					best_row_q   <= '0;
				end else if (in_mode == MODE_START) begin
					col_pos_q     <= in_col_start;
					row_pos_q     <= in_row_start;
					col_inc_q     <= in_col_step;
					row_dec_q     <= in_row_step;
					group_count_q <= '0;
				end else if (in_mode == MODE_GROUP &&
				             group_count_q < range_groups_q) begin
					col_pos_q <= col_pos_q + col_inc_q;
					row_pos_q <= row_pos_q - row_dec_q;
					if (group_count_q != 8'hFF) begin
						group_count_q <= group_count_q + 8'd1;
					end
				end
			end
			if (upd_fire && new_peak) begin
				best_value_q <= group_max;
				best_col_q   <= ci_q;
				best_row_q   <= ri_q;
			end
		end
	end

	// Word held for the update cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q     <= in_mode;
			codes_q    <= in_codes;
			on_grid_q  <= acc_on_grid;
			in_range_q <= (group_count_q < range_groups_q);
			addr_q     <= acc_addr;
			ci_q       <= ci16[PCW-1:0];
			ri_q       <= ri16[PRW-1:0];
		end
	end

	// Output register.
	logic [MAG_W-1:0]      peak_val_n;
	logic [15:0]           peak_col_16, peak_row_16;
	logic [OUT_DATA_W-1:0] res_data;

	always_comb begin
		peak_val_n  = new_peak ? group_max : best_value_q;
		peak_col_16 = new_peak ? 16'(ci_q) : 16'(best_col_q);
		peak_row_16 = new_peak ? 16'(ri_q) : 16'(best_row_q);
		res_data    = {peak_row_16[PEAK_POS_W-1:0], peak_col_16[PEAK_POS_W-1:0],
		               peak_val_n, box_val};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			out_data_q <= res_data;
			out_user_q <= off_val;
		end
	end

	assign out_tvalid = out_valid_q;
	assign out_tdata  = out_data_q;
	assign out_tuser  = out_user_q;

endmodule

/* hdl/pg_grid_ram.sv */
// Grid box memory: one write port and one registered read port.
`timescale 1ns / 1ps

module pg_grid_ram #(
	parameter int AW = 12,
	parameter int DW = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/pg_gate_max.sv */
// Folds the velocity codes of one gate group to magnitudes and takes their maximum.
`timescale 1ns / 1ps

module pg_gate_max
	import pg_pkg::*;
(
	input  codes_t             codes,
	input  logic [CODE_W-1:0]  limit,
	output logic [MAG_W-1:0]   group_max
);

	logic [MAG_W-1:0] mag [GATES_PER_GROUP];
	logic [MAG_W-1:0] pair_lo;
	logic [MAG_W-1:0] pair_hi;

	// Invalid codes count as zero; low codes fold around the midpoint.
	always_comb begin
		for (int g = 0; g < GATES_PER_GROUP; g++) begin
			if (codes[g] <= limit) begin
				mag[g] = '0;
			end else if (MAG_W'(codes[g]) < FOLD_BELOW) begin
				mag[g] = FOLD_BASE - MAG_W'(codes[g]);
			end else begin
				mag[g] = MAG_W'(codes[g]);
			end
		end
	end

	// Two-level maximum tree over the four gates.
	always_comb begin
		pair_lo   = (mag[1] > mag[0]) ? mag[1] : mag[0];
		pair_hi   = (mag[3] > mag[2]) ? mag[3] : mag[2];
		group_max = (pair_hi > pair_lo) ? pair_hi : pair_lo;
	end

endmodule

/* hdl/pg_checker.sv */
// Port-level checks of the polar-to-grid max-hold block and their binding.
`timescale 1ns / 1ps

module pg_checker
	import pg_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_tvalid,
	input logic                  out_tready,
	input logic [OUT_DATA_W-1:0] out_tdata,
	input logic                  out_tuser
);

	// A stalled result word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
		$stable(out_tuser))
		else $error("stalled result word changed");

	// No box can hold more than the peak since the last clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid |-> out_tdata[8:0] <= out_tdata[17:9])
		else $error("box value above peak value");

	// Without a peak there is no peak position.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid && out_tdata[17:9] == 9'd0 |->
		out_tdata[24:18] == 7'd0 && out_tdata[31:25] == 7'd0)
		else $error("peak position without peak value");

	// An off-grid word reports an empty box.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid && out_tuser |-> out_tdata[8:0] == 9'd0)
		else $error("off-grid word with box value");

endmodule

bind polar_to_grid_max_velocity pg_checker u_pg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_tvalid (out_tvalid),
	.out_tready (out_tready),
	.out_tdata  (out_tdata),
	.out_tuser  (out_tuser)
);
